// ----- src/bsct_pkg.sv -----
// ----------------------------------------------------------------------------
// bsct_pkg
// Shared sizes, codes and controller/datapath bundles for the cell table.
// ----------------------------------------------------------------------------
package bsct_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ID_W        = 16;
  localparam int QUAL_W      = 7;
  localparam int STAT_W      = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic start;   // latch request, clear scan state
    logic issue;   // read table entry at scan index, advance index
    logic commit;  // apply insert or remove to count and best
    logic emit;    // load result register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic last_issue;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- src/bsct_if.sv -----
// ----------------------------------------------------------------------------
// bsct_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface bsct_req_if;
  import bsct_pkg::*;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [ID_W-1:0]   cell_id;
  logic [QUAL_W-1:0] quality;

  modport source (output valid, operation, cell_id, quality, input ready);
  modport sink   (input valid, operation, cell_id, quality, output ready);
endinterface

interface bsct_rsp_if;
  import bsct_pkg::*;
  logic              valid;
  logic              ready;
  logic              best_valid;
  logic [ID_W-1:0]   best_id;
  logic [QUAL_W-1:0] best_quality;
  logic [STAT_W-1:0] status;
  logic [CNT_W-1:0]  occupancy;

  modport source (output valid, best_valid, best_id, best_quality, status, occupancy,
                  input ready);
  modport sink   (input valid, best_valid, best_id, best_quality, status, occupancy,
                  output ready);
endinterface

// ----- src/bsct_ctrl.sv -----
// ----------------------------------------------------------------------------
// bsct_ctrl
// Sequencer: accept, scan the table on remove, commit, hand off the result.
// ----------------------------------------------------------------------------
module bsct_ctrl
  import bsct_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_op,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_FIN   = 5'b01000,
    S_WB    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          // an empty table has nothing to scan
          if (in_op == OP_REMOVE && !sts.empty) state_nxt = S_SCAN;
          else                                 state_nxt = S_FIN;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.last_issue) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_FIN;
      S_FIN: begin
        cmd.commit = 1'b1;
        state_nxt  = S_WB;
      end
      S_WB: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ----- src/bsct_dp.sv -----
// ----------------------------------------------------------------------------
// bsct_dp
// Cell table memory, count, cached best entry, scan pipeline, result register.
// ----------------------------------------------------------------------------
module bsct_dp
  import bsct_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts,
  input  logic              in_operation,
  input  logic [ID_W-1:0]   in_cell_id,
  input  logic [QUAL_W-1:0] in_quality,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_best_valid,
  output logic [ID_W-1:0]   out_best_id,
  output logic [QUAL_W-1:0] out_best_quality,
  output logic [STAT_W-1:0] out_status,
  output logic [CNT_W-1:0]  out_occupancy
);

  logic [ID_W-1:0]   mem_id [TABLE_DEPTH];
  logic [QUAL_W-1:0] mem_q  [TABLE_DEPTH];

  logic              req_op_r;
  logic [ID_W-1:0]   req_id_r;
  logic [QUAL_W-1:0] req_q_r;

  logic [CNT_W-1:0]  count_r;
  logic [IDX_W-1:0]  best_slot_r;
  logic [ID_W-1:0]   best_id_r;
  logic [QUAL_W-1:0] best_q_r;
  logic [STAT_W-1:0] status_r;

  // scan pipeline: address issued, data registered and returned in the next cycle
  logic [IDX_W-1:0]  idx_r;
  logic              rv_r;
  logic [IDX_W-1:0]  ridx_r;
  logic [ID_W-1:0]   rd_id_r;
  logic [QUAL_W-1:0] rd_q_r;

  logic              found_r;
  logic [IDX_W-1:0]  hit_r;
  logic              cand_valid_r;
  logic [IDX_W-1:0]  cand_idx_r;
  logic [ID_W-1:0]   cand_id_r;
  logic [QUAL_W-1:0] cand_q_r;

  logic              out_valid_r;
  logic              out_best_valid_r;
  logic [ID_W-1:0]   out_best_id_r;
  logic [QUAL_W-1:0] out_best_q_r;
  logic [STAT_W-1:0] out_status_r;
  logic [CNT_W-1:0]  out_occ_r;

  logic              is_full;
  logic              is_hit;
  logic [IDX_W-1:0]  new_idx;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [ID_W-1:0]   wr_id;
  logic [QUAL_W-1:0] wr_q;

  assign is_full = (count_r == CNT_W'(TABLE_DEPTH));
  assign is_hit  = rv_r && !found_r && (rd_id_r == req_id_r);
  // index of the streamed entry once the removed one is gone
  assign new_idx = found_r ? ridx_r - 1'b1 : ridx_r;

  assign sts.empty      = (count_r == '0);
  assign sts.last_issue = ((CNT_W'(idx_r) + 1'b1) == count_r);
  assign sts.out_free   = !out_valid_r || out_ready;

  // single write port: append on insert commit, shift down during remove scan
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ridx_r - 1'b1;
    wr_id   = rd_id_r;
    wr_q    = rd_q_r;
    if (cmd.commit && req_op_r == OP_INSERT && !is_full) begin
      wr_en   = 1'b1;
      wr_addr = count_r[IDX_W-1:0];
      wr_id   = req_id_r;
      wr_q    = req_q_r;
    end else if (rv_r && found_r) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_id[wr_addr] <= wr_id;
      mem_q[wr_addr]  <= wr_q;
    end
    if (cmd.issue) begin
      rd_id_r <= mem_id[idx_r];
      rd_q_r  <= mem_q[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_op_r <= in_operation;
      req_id_r <= in_cell_id;
      req_q_r  <= in_quality;
    end
    if (cmd.issue) ridx_r <= idx_r;
    if (is_hit) hit_r <= ridx_r;
    if (rv_r && !is_hit && (!cand_valid_r || rd_q_r > cand_q_r)) begin
      cand_idx_r <= new_idx;
      cand_id_r  <= rd_id_r;
      cand_q_r   <= rd_q_r;
    end
    if (cmd.emit) begin
      out_best_valid_r <= (count_r != '0);
      out_best_id_r    <= (count_r != '0) ? best_id_r : '0;
      out_best_q_r     <= (count_r != '0) ? best_q_r : '0;
      out_status_r     <= status_r;
      out_occ_r        <= count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      best_slot_r  <= '0;
      status_r     <= ST_DONE;
      idx_r        <= '0;
      rv_r         <= 1'b0;
      found_r      <= 1'b0;
      cand_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      rv_r <= cmd.issue;
      if (cmd.start) begin
        idx_r        <= '0;
        found_r      <= 1'b0;
        cand_valid_r <= 1'b0;
      end else if (cmd.issue) begin
        idx_r <= idx_r + 1'b1;
      end
      if (is_hit) found_r <= 1'b1;
      if (rv_r && !is_hit) cand_valid_r <= 1'b1;

      if (cmd.commit) begin
        status_r <= ST_DONE;
        if (req_op_r == OP_INSERT) begin
          if (is_full) begin
            status_r <= ST_FULL;
          end else begin
            count_r <= count_r + 1'b1;
            if (count_r == '0 || req_q_r > best_q_r) begin
              best_slot_r <= count_r[IDX_W-1:0];
              best_id_r   <= req_id_r;
              best_q_r    <= req_q_r;
            end
          end
        end else if (!found_r) begin
          status_r <= ST_NOTFOUND;
        end else begin
          count_r <= count_r - 1'b1;
          priority if (count_r == CNT_W'(1)) begin
            best_slot_r <= '0;
          end else if (hit_r == best_slot_r) begin
            best_slot_r <= cand_idx_r;
            best_id_r   <= cand_id_r;
            best_q_r    <= cand_q_r;
          end else if (hit_r < best_slot_r) begin
            best_slot_r <= best_slot_r - 1'b1;
          end else begin
            best_slot_r <= best_slot_r;
          end
        end
      end

      if (cmd.emit)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_best_valid   = out_best_valid_r;
  assign out_best_id      = out_best_id_r;
  assign out_best_quality = out_best_q_r;
  assign out_status       = out_status_r;
  assign out_occupancy    = out_occ_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("table count above depth");

  a_best_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != '0 |-> CNT_W'(best_slot_r) < count_r)
    else $error("best slot outside occupied entries");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_FULL |-> out_occ_r == CNT_W'(TABLE_DEPTH))
    else $error("full status with free entries");

  a_hit_once: assert property (@(posedge clk) disable iff (!rst_n)
    found_r && rv_r |-> !is_hit)
    else $error("second match taken during remove scan");

  a_valid_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_best_valid_r == (out_occ_r != '0))
    else $error("best valid disagrees with occupancy");
`endif

endmodule

// ----- src/best_signal_cell_table_top.sv -----
// ----------------------------------------------------------------------------
// best_signal_cell_table_top
// Ordered table of up to TABLE_DEPTH cells with best-quality tracking.
// ----------------------------------------------------------------------------
// Usage:
//   in_bus carries one request per beat: insert (operation 0) appends a cell,
//   remove (operation 1) takes out the earliest cell with that identifier.
//   out_bus returns one result beat per request: best cell, status, occupancy.
// Sequencing:
//   Insert, or remove on an empty table: the accepted request is committed,
//   then its result is loaded into the output register once that is free;
//   the next request is taken after the load. Remove: the table is scanned
//   and the last read drains before commit and load. One pass over the
//   table memory, one entry per cycle, finds the match, shifts later entries
//   down and picks the new best. One request is in flight at a time.
// Reset:
//   rst_n low clears the count and best slot; the table is empty afterwards.
// Stalls:
//   A result waits in the output register while out_bus.ready is low; the
//   next request is still accepted and worked, and its result is held back
//   until the register frees.
// ----------------------------------------------------------------------------
module best_signal_cell_table_top
  import bsct_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  bsct_req_if.sink   in_bus,
  bsct_rsp_if.source out_bus
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  bsct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_op    (in_bus.operation),
    .in_ready (in_bus.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bsct_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_operation     (in_bus.operation),
    .in_cell_id       (in_bus.cell_id),
    .in_quality       (in_bus.quality),
    .out_valid        (out_bus.valid),
    .out_ready        (out_bus.ready),
    .out_best_valid   (out_bus.best_valid),
    .out_best_id      (out_bus.best_id),
    .out_best_quality (out_bus.best_quality),
    .out_status       (out_bus.status),
    .out_occupancy    (out_bus.occupancy)
  );

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for best_signal_cell_table_top. Request beats come from
// a queue: a directed opening, then random insert/remove traffic in phases
// that lean toward filling or draining the table or stay balanced. An in-bench model of the
// cell table predicts each result beat, and the beats are compared field by
// field in order. Both channels idle at random, and once the result side
// holds off long enough to back up the request side.
// ----------------------------------------------------------------------------
module testbench;
  import bsct_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_OPS  = 1750;
  localparam int QUIET_LIMIT = 3000;
  localparam int LONG_HOLD   = 500;

  typedef struct {
    logic              op;
    logic [ID_W-1:0]   id;
    logic [QUAL_W-1:0] qual;
  } cell_op_t;

  typedef struct {
    logic              best_valid;
    logic [ID_W-1:0]   best_id;
    logic [QUAL_W-1:0] best_quality;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  occupancy;
  } best_report_t;

  logic clk;
  logic rst_n;

  bsct_req_if cell_req ();
  bsct_rsp_if best_rsp ();

  best_signal_cell_table_top uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (cell_req),
    .out_bus (best_rsp)
  );

  // table model
  logic [ID_W-1:0]   cell_ids   [TABLE_DEPTH];
  logic [QUAL_W-1:0] cell_quals [TABLE_DEPTH];
  int                cell_count = 0;
  int                best_idx   = 0;

  cell_op_t        ops_to_send[$];
  best_report_t    best_reports_due[$];
  logic [ID_W-1:0] gen_ids[$];     // ids the generator believes are in the table

  cell_op_t op_now;
  int       send_gap   = 0;
  int       hold_left  = 0;
  bit       long_hold_done = 0;
  int       beats_in   = 0;
  int       quiet      = 0;
  int       cycle_count = 0;
  int       errors     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic best_report_t apply_cell_op(logic op, logic [ID_W-1:0] id,
                                                 logic [QUAL_W-1:0] qual);
    best_report_t r;
    int hit;
    int i;
    r.status = ST_DONE;
    hit = -1;
    if (op == OP_INSERT) begin
      if (cell_count >= TABLE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        cell_ids[cell_count]   = id;
        cell_quals[cell_count] = qual;
        if (cell_count == 0 || qual > cell_quals[best_idx]) best_idx = cell_count;
        cell_count++;
      end
    end else begin
      for (i = 0; i < cell_count; i++)
        if (hit < 0 && cell_ids[i] == id) hit = i;
      if (hit < 0) begin
        r.status = ST_NOTFOUND;
      end else begin
        for (i = hit; i + 1 < cell_count; i++) begin
          cell_ids[i]   = cell_ids[i + 1];
          cell_quals[i] = cell_quals[i + 1];
        end
        cell_count--;
        if (cell_count == 0) begin
          best_idx = 0;
        end else if (hit == best_idx) begin
          // first entry with the top quality wins
          best_idx = 0;
          for (i = 1; i < cell_count; i++)
            if (cell_quals[i] > cell_quals[best_idx]) best_idx = i;
        end else if (hit < best_idx) begin
          best_idx--;
        end
      end
    end
    if (cell_count > 0) begin
      r.best_valid   = 1'b1;
      r.best_id      = cell_ids[best_idx];
      r.best_quality = cell_quals[best_idx];
    end else begin
      r.best_valid   = 1'b0;
      r.best_id      = '0;
      r.best_quality = '0;
    end
    r.occupancy = CNT_W'(cell_count);
    return r;
  endfunction

  // mostly short gaps, a few long ones; none in calm windows
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (cycle_count % 2500 < 400) return 0;
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic queue_op(logic op, logic [ID_W-1:0] id, logic [QUAL_W-1:0] qual);
    int hit;
    hit = -1;
    ops_to_send.push_back('{op, id, qual});
    if (op == OP_INSERT) begin
      if (gen_ids.size() < TABLE_DEPTH) gen_ids.push_back(id);
    end else begin
      foreach (gen_ids[k])
        if (hit < 0 && gen_ids[k] == id) hit = k;
      if (hit >= 0) gen_ids.delete(hit);
    end
  endtask

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      cell_req.valid <= 1'b0;
      send_gap       <= 0;
    end else if (!cell_req.valid || cell_req.ready) begin
      if (send_gap > 0) begin
        cell_req.valid <= 1'b0;
        send_gap       <= send_gap - 1;
      end else if (ops_to_send.size() > 0) begin
        op_now = ops_to_send.pop_front();
        cell_req.valid     <= 1'b1;
        cell_req.operation <= op_now.op;
        cell_req.cell_id   <= op_now.id;
        cell_req.quality   <= op_now.qual;
        send_gap           <= pick_gap();
      end else begin
        cell_req.valid <= 1'b0;
      end
    end
  end

  // result-side ready, with one long hold-off once traffic is flowing
  always @(posedge clk) begin
    if (!rst_n) begin
      best_rsp.ready <= 1'b0;
      hold_left      <= 0;
    end else if (!long_hold_done && beats_in >= 300) begin
      long_hold_done <= 1'b1;
      hold_left      <= LONG_HOLD;
      best_rsp.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left      <= hold_left - 1;
      best_rsp.ready <= 1'b0;
    end else begin
      best_rsp.ready <= 1'b1;
      hold_left      <= pick_gap();
    end
  end

  // prediction on accepted requests, checking on accepted results
  always @(posedge clk) begin : monitor
    best_report_t due;
    if (rst_n) begin
      if (cell_req.valid && cell_req.ready) begin
        best_reports_due.push_back(apply_cell_op(cell_req.operation, cell_req.cell_id,
                                                 cell_req.quality));
        beats_in <= beats_in + 1;
      end
      if (best_rsp.valid && best_rsp.ready) begin
        if (best_reports_due.size() == 0) begin
          $display("%0t: result beat with none expected, expected nothing, got id %0d",
                   $time, best_rsp.best_id);
          errors++;
        end else begin
          due = best_reports_due.pop_front();
          check_field("best_valid", 32'(due.best_valid), 32'(best_rsp.best_valid));
          check_field("best_id", 32'(due.best_id), 32'(best_rsp.best_id));
          check_field("best_quality", 32'(due.best_quality), 32'(best_rsp.best_quality));
          check_field("status", 32'(due.status), 32'(best_rsp.status));
          check_field("occupancy", 32'(due.occupancy), 32'(best_rsp.occupancy));
        end
      end
    end
  end

  // watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n || (cell_req.valid && cell_req.ready) || (best_rsp.valid && best_rsp.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("best_signal_cell_table_top: mismatch");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int n;
    int i;
    int roll;
    int ins_pct;
    logic [ID_W-1:0]   id;
    logic [QUAL_W-1:0] qual;

    rst_n              = 1'b0;
    cell_req.valid     = 1'b0;
    cell_req.operation = OP_INSERT;
    cell_req.cell_id   = '0;
    cell_req.quality   = '0;
    best_rsp.ready     = 1'b0;

    // directed opening
    queue_op(OP_REMOVE, 16'h1234, 7'd0);     // remove from empty table
    queue_op(OP_INSERT, 16'h0000, 7'd0);     // first cell is best regardless
    queue_op(OP_INSERT, 16'hFFFF, 7'd0);     // equal quality, best stays
    queue_op(OP_INSERT, 16'h00AA, 7'd100);
    queue_op(OP_INSERT, 16'h0000, 7'd127);   // duplicate id, quality over 100
    queue_op(OP_INSERT, 16'h5555, 7'd127);   // tie, earlier stays best
    queue_op(OP_REMOVE, 16'h0000, 7'd127);   // earliest dup, ahead of best
    queue_op(OP_REMOVE, 16'hBEEF, 7'd55);    // not found
    for (i = 0; i < 12; i++)
      queue_op(OP_INSERT, ID_W'(16'h8000 + i), QUAL_W'(i * 8));
    queue_op(OP_INSERT, 16'h7777, 7'd126);   // full table, dropped
    queue_op(OP_REMOVE, 16'h0000, 7'd0);     // removes best, rescan to tie
    queue_op(OP_REMOVE, 16'hFFFF, 7'd0);     // head entry, best shifts down

    // random phases leaning toward fill or drain, or balanced
    ins_pct = 50;
    for (n = 0; n < RANDOM_OPS; n++) begin
      if (n % 120 == 0) begin
        case ($urandom_range(0, 2))
          0: ins_pct = 15;
          1: ins_pct = 50;
          default: ins_pct = 85;
        endcase
      end
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < ins_pct) begin
        if (roll < 50) id = ID_W'($urandom_range(0, 15));
        else if (roll < 65 && gen_ids.size() > 0) id = gen_ids[$urandom_range(0, gen_ids.size() - 1)];
        else id = ID_W'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 70) qual = QUAL_W'($urandom_range(0, 100));
        else if (roll < 90) qual = QUAL_W'(50 * $urandom_range(0, 2));
        else qual = QUAL_W'($urandom_range(101, 127));
        queue_op(OP_INSERT, id, qual);
      end else begin
        if (gen_ids.size() > 0 && roll < 85) id = gen_ids[$urandom_range(0, gen_ids.size() - 1)];
        else if (roll < 93) id = ID_W'($urandom_range(0, 15));
        else id = ID_W'($urandom);
        queue_op(OP_REMOVE, id, QUAL_W'($urandom_range(0, 127)));
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (ops_to_send.size() != 0 || cell_req.valid || best_reports_due.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);

    if (errors == 0 && best_reports_due.size() == 0) begin
      $display("best_signal_cell_table_top: match");
    end else begin
      $display("best_signal_cell_table_top: mismatch");
    end
    $finish;
  end

endmodule
